// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ADPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ADPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/adpi_pkg.sv =====
// Shared widths, register-file constants and instruction codes for the
// data-processing-immediate executor. No dependencies.
`default_nettype none

package adpi_pkg;

  localparam int INSTR_W     = 32;
  localparam int DATA_W      = 64;
  localparam int FLAGS_W     = 4;
  localparam int REG_IDX_W   = 5;
  localparam int NUM_GP_REGS = 31;

  // Register 31: stack pointer or zero register, depending on the opcode.
  localparam logic [REG_IDX_W-1:0] REG_SP_ZR = 5'd31;

  // Wide-move opc codes; the remaining code executes as movn.
  localparam logic [1:0] OPC_MOVN = 2'b00;
  localparam logic [1:0] OPC_MOVZ = 2'b10;
  localparam logic [1:0] OPC_MOVK = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/adpi_instr_if.sv =====
// Instruction channel: valid/ready handshake carrying one instruction word.
// Depends on adpi_pkg.
`default_nettype none

interface adpi_instr_if;
  logic                          valid;
  logic                          ready;
  logic [adpi_pkg::INSTR_W-1:0]  instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/adpi_result_if.sv =====
// Result channel: valid/ready handshake carrying one execution result.
// Depends on adpi_pkg.
`default_nettype none

interface adpi_result_if;
  logic                            valid;
  logic                            ready;
  logic                            handled;
  logic                            dest_written;
  logic [adpi_pkg::REG_IDX_W-1:0]  dest_index;
  logic [adpi_pkg::DATA_W-1:0]     dest_value;
  logic [adpi_pkg::FLAGS_W-1:0]    flags_nzcv;

  modport source (output valid, output handled, output dest_written, output dest_index,
                  output dest_value, output flags_nzcv, input ready);
  modport sink   (input valid, input handled, input dest_written, input dest_index,
                  input dest_value, input flags_nzcv, output ready);
endinterface

`default_nettype wire

// ===== rtl/adpi_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Read-first on a same-address write. No dependencies.
`default_nettype none

module adpi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                         rdata_a,
  output logic [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/armv8_immediate_dp_executor_core.sv =====
// Data-processing-immediate executor: add/adds/sub/subs and movn/movz/movk.
// Depends on adpi_pkg, adpi_instr_if, adpi_result_if and adpi_ram.
//
// Usage:
//   instr  (sink)   : one 32-bit instruction word per transfer.
//   result (source) : one result per instruction: handled, dest_written,
//                     dest_index, dest_value and the NZCV flags after it.
// Pipeline: the instruction word and the register-file read are registered
//   together in the execute stage, and execute feeds the result register.
// Throughput: one instruction per cycle while results are taken. The register file is read when an
//   instruction is taken and written as it leaves execute; a write in that same
//   cycle is forwarded, so back-to-back dependent instructions need no stall.
// Reset (rst, synchronous): empties the pipeline and clears all 31 general
//   registers (valid bits), the stack pointer and the flags.
// Stall: while a result waits and result.ready is low the result register holds, the execute
//   stage holds its instruction, and instr.ready drops once both are full.
`default_nettype none

module armv8_immediate_dp_executor_core (
  input  logic                 clk,
  input  logic                 rst,
  adpi_instr_if.sink           instr,
  adpi_result_if.source        result
);

  localparam int RamAw = (adpi_pkg::NUM_GP_REGS > 1) ? $clog2(adpi_pkg::NUM_GP_REGS) : 1;

  // Pipeline control
  logic                             s1_valid;
  logic [adpi_pkg::INSTR_W-1:0]     s1_word;
  logic                             out_valid;
  logic                             advance;
  logic                             accept;

  // Register file, valid bits and forwarding
  logic [adpi_pkg::NUM_GP_REGS:0]   gp_valid;
  logic                             valid_a;
  logic                             valid_b;
  logic                             byp_a;
  logic                             byp_b;
  logic [adpi_pkg::DATA_W-1:0]      byp_data;
  logic [adpi_pkg::DATA_W-1:0]      ram_a;
  logic [adpi_pkg::DATA_W-1:0]      ram_b;
  logic [adpi_pkg::DATA_W-1:0]      reg_a;
  logic [adpi_pkg::DATA_W-1:0]      reg_b;
  logic                             gp_we;
  logic [RamAw-1:0]                 gp_waddr;
  logic [RamAw-1:0]                 raddr_a;
  logic [RamAw-1:0]                 raddr_b;

  // Architectural state
  logic [adpi_pkg::DATA_W-1:0]      sp;
  logic [adpi_pkg::FLAGS_W-1:0]     flags;

  // Decode
  logic                             is_arith;
  logic                             is_wide;
  logic [adpi_pkg::REG_IDX_W-1:0]   rd;
  logic [adpi_pkg::REG_IDX_W-1:0]   rn;
  logic [1:0]                       opc;
  logic                             sf;
  logic                             is_sub;
  logic                             set_flags;

  // Arithmetic datapath
  logic [adpi_pkg::DATA_W-1:0]      imm_arith;
  logic [adpi_pkg::DATA_W-1:0]      op_a;
  logic [adpi_pkg::DATA_W-1:0]      op_b;
  logic [adpi_pkg::DATA_W:0]        sum;
  logic [adpi_pkg::DATA_W-1:0]      arith_res;
  logic                             c64;
  logic                             c32;
  logic                             v64;
  logic                             v32;
  logic [adpi_pkg::FLAGS_W-1:0]     arith_flags;

  // Wide-move datapath
  logic [5:0]                       wide_sh;
  logic [adpi_pkg::DATA_W-1:0]      wide_op;
  logic [adpi_pkg::DATA_W-1:0]      wide_mask;
  logic [adpi_pkg::DATA_W-1:0]      wide_raw;
  logic [adpi_pkg::DATA_W-1:0]      wide_res;

  // Step outcome
  logic                             wr_gp;
  logic                             wr_sp;
  logic                             dest_wr;
  logic [adpi_pkg::DATA_W-1:0]      exec_res;
  logic [adpi_pkg::FLAGS_W-1:0]     flags_next;

  assign advance     = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || advance;
  assign accept      = instr.valid && instr.ready;

  assign raddr_a  = instr.instr_word[9:5];
  assign raddr_b  = instr.instr_word[4:0];
  assign gp_we    = advance && wr_gp;
  assign gp_waddr = rd;

  adpi_ram #(
    .WIDTH (adpi_pkg::DATA_W),
    .DEPTH (adpi_pkg::NUM_GP_REGS)
  ) u_gp_ram (
    .clk     (clk),
    .we      (gp_we),
    .waddr   (gp_waddr),
    .wdata   (exec_res),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // Never-written registers read as zero; a write in the read cycle wins.
  assign reg_a = byp_a ? byp_data : (valid_a ? ram_a : '0);
  assign reg_b = byp_b ? byp_data : (valid_b ? ram_b : '0);

  // Decode
  assign rd        = s1_word[4:0];
  assign rn        = s1_word[9:5];
  assign opc       = s1_word[30:29];
  assign sf        = s1_word[31];
  assign is_arith  = s1_word[24];
  assign is_wide   = !s1_word[24] && s1_word[25] && s1_word[23];
  assign is_sub    = opc[1];
  assign set_flags = opc[0];

  // Add/subtract: a + (b or ~b) + carry-in, flags from the same adder
  always_comb begin
    imm_arith = s1_word[22] ? {40'd0, s1_word[21:10], 12'd0} : {52'd0, s1_word[21:10]};
    if (rn == adpi_pkg::REG_SP_ZR) begin
      op_a = set_flags ? '0 : sp;
    end else begin
      op_a = reg_a;
    end
    op_b = is_sub ? ~imm_arith : imm_arith;
    sum  = {1'b0, op_a} + {1'b0, op_b} + {{adpi_pkg::DATA_W{1'b0}}, is_sub};
    c64  = sum[adpi_pkg::DATA_W];
    c32  = sum[32] ^ op_a[32] ^ op_b[32];
    v64  = (op_a[63] ^ sum[63]) & (op_b[63] ^ sum[63]);
    v32  = (op_a[31] ^ sum[31]) & (op_b[31] ^ sum[31]);
    if (sf) begin
      arith_res   = sum[adpi_pkg::DATA_W-1:0];
      arith_flags = {sum[63], (sum[63:0] == '0), c64, v64};
    end else begin
      arith_res   = {32'd0, sum[31:0]};
      arith_flags = {sum[31], (sum[31:0] == '0), c32, v32};
    end
  end

  // Wide move: imm16 placed at halfword hw
  always_comb begin
    wide_sh   = {s1_word[22:21], 4'd0};
    wide_op   = {48'd0, s1_word[20:5]} << wide_sh;
    wide_mask = {48'd0, 16'hFFFF} << wide_sh;
    unique case (opc)
      adpi_pkg::OPC_MOVK: wide_raw = (reg_b & ~wide_mask) | wide_op;
      adpi_pkg::OPC_MOVZ: wide_raw = wide_op;
      default:            wide_raw = ~wide_op;
    endcase
    wide_res = sf ? wide_raw : {32'd0, wide_raw[31:0]};
  end

  // Destination selection
  always_comb begin
    wr_gp      = 1'b0;
    wr_sp      = 1'b0;
    exec_res   = arith_res;
    flags_next = flags;
    if (is_arith) begin
      if (rd != adpi_pkg::REG_SP_ZR) begin
        wr_gp = 1'b1;
      end else begin
        wr_sp = !set_flags;
      end
      if (set_flags) begin
        flags_next = arith_flags;
      end
    end else if (is_wide) begin
      exec_res = wide_res;
      wr_gp    = (rd != adpi_pkg::REG_SP_ZR);
    end
    dest_wr = wr_gp || wr_sp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      gp_valid  <= '0;
      sp        <= '0;
      flags     <= '0;
      byp_a     <= 1'b0;
      byp_b     <= 1'b0;
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
    end else begin
      // Capture read-side context together with the RAM read
      if (accept) begin
        s1_word  <= instr.instr_word;
        valid_a  <= gp_valid[raddr_a];
        valid_b  <= gp_valid[raddr_b];
        byp_a    <= gp_we && (gp_waddr == raddr_a);
        byp_b    <= gp_we && (gp_waddr == raddr_b);
        byp_data <= exec_res;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid           <= 1'b1;
        result.handled      <= is_arith || is_wide;
        result.dest_written <= dest_wr;
        result.dest_index   <= dest_wr ? rd : '0;
        result.dest_value   <= dest_wr ? exec_res : '0;
        result.flags_nzcv   <= flags_next;
        flags               <= flags_next;
        if (wr_sp) begin
          sp <= exec_res;
        end
        if (wr_gp) begin
          gp_valid[rd] <= 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/adpi_checker.sv =====
// Port-level checks for the executor, bound to the top level.
// Depends on assert_macros.svh and adpi_pkg.
`default_nettype none
`include "assert_macros.svh"

module adpi_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            handled,
  input wire logic                            dest_written,
  input wire logic [adpi_pkg::REG_IDX_W-1:0]  dest_index,
  input wire logic [adpi_pkg::DATA_W-1:0]     dest_value,
  input wire logic [adpi_pkg::FLAGS_W-1:0]    flags_nzcv
);

  logic [adpi_pkg::FLAGS_W-1:0] last_flags;

  // Track the flags of the last transferred result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_flags <= '0;
    end else if (out_valid && out_ready) begin
      last_flags <= flags_nzcv;
    end
  end

  `ADPI_ASSERT(a_valid_held, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ADPI_ASSERT(a_write_handled, out_valid && dest_written |-> handled, "write from unhandled word")
  `ADPI_ASSERT(a_idle_dest_zero, out_valid && !dest_written |-> (dest_index == '0) && (dest_value == '0), "dest fields not cleared")
  `ADPI_ASSERT(a_flags_kept, out_valid && !handled |-> flags_nzcv == last_flags, "flags changed by unhandled word")

endmodule

bind armv8_immediate_dp_executor_core adpi_checker u_adpi_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .handled      (result.handled),
  .dest_written (result.dest_written),
  .dest_index   (result.dest_index),
  .dest_value   (result.dest_value),
  .flags_nzcv   (result.flags_nzcv)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for armv8_immediate_dp_executor_core: a built-in executor
// predicts each result of the add/sub-immediate and wide-move groups.
// Depends on adpi_pkg, adpi_instr_if, adpi_result_if and the core itself.

module testbench;

  // Arithmetic opc codes; the wide-move code 01 is the unnamed alias of movn.
  localparam logic [1:0] OPC_ADD      = 2'b00;
  localparam logic [1:0] OPC_ADDS     = 2'b01;
  localparam logic [1:0] OPC_SUB      = 2'b10;
  localparam logic [1:0] OPC_SUBS     = 2'b11;
  localparam logic [1:0] OPC_MOVN_ALT = 2'b01;

  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic                           handled;
    logic                           dest_written;
    logic [adpi_pkg::REG_IDX_W-1:0] dest_index;
    logic [adpi_pkg::DATA_W-1:0]    dest_value;
    logic [adpi_pkg::FLAGS_W-1:0]   flags_nzcv;
  } exec_result_t;

  logic clk;
  logic rst;

  adpi_instr_if  instr ();
  adpi_result_if result ();

  armv8_immediate_dp_executor_core dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .result (result)
  );

  // Architectural state as the executor sees it
  logic [adpi_pkg::DATA_W-1:0]  gp_regs [adpi_pkg::NUM_GP_REGS];
  logic [adpi_pkg::DATA_W-1:0]  sp_reg;
  logic [adpi_pkg::FLAGS_W-1:0] nzcv;

  exec_result_t expected_q [$];
  int  n_issued;
  int  n_checked = 0;
  int  n_arith;
  int  n_wide;
  int  n_other;
  int  n_mismatch = 0;
  int  idle_cycles = 0;
  logic steady_flow;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none while steady_flow is set
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic exec_result_t execute_instr(input logic [adpi_pkg::INSTR_W-1:0] w);
    exec_result_t                 r;
    logic [4:0]                   rd;
    logic [4:0]                   rn;
    logic [1:0]                   opc;
    logic                         sf;
    logic                         subtract;
    logic                         sets_flags;
    logic [adpi_pkg::DATA_W-1:0]  imm;
    logic [adpi_pkg::DATA_W-1:0]  a;
    logic [adpi_pkg::DATA_W-1:0]  b;
    logic [adpi_pkg::DATA_W-1:0]  res;
    logic [adpi_pkg::DATA_W-1:0]  op;
    logic [adpi_pkg::DATA_W-1:0]  sign_mix;
    logic [adpi_pkg::DATA_W:0]    sum;
    logic [5:0]                   sh;
    logic                         carry;
    logic                         ovf;
    r   = '0;
    res = '0;
    rd  = w[4:0];
    rn  = w[9:5];
    opc = w[30:29];
    sf  = w[31];
    if (w[24]) begin
      r.handled  = 1'b1;
      n_arith++;
      subtract   = (opc == OPC_SUB) || (opc == OPC_SUBS);
      sets_flags = (opc == OPC_ADDS) || (opc == OPC_SUBS);
      imm = {52'd0, w[21:10]};
      if (w[22]) imm = imm << 12;
      if (rn == adpi_pkg::REG_SP_ZR) a = sets_flags ? '0 : sp_reg;
      else a = gp_regs[rn];
      b = subtract ? ~imm : imm;
      if (sf) begin
        sum      = {1'b0, a} + {1'b0, b} + {64'd0, subtract};
        res      = sum[63:0];
        carry    = sum[64];
        sign_mix = (a ^ res) & (b ^ res);
        ovf      = sign_mix[63];
      end else begin
        sum      = {33'd0, a[31:0]} + {33'd0, b[31:0]} + {64'd0, subtract};
        res      = {32'd0, sum[31:0]};
        carry    = sum[32];
        sign_mix = ({32'd0, a[31:0]} ^ res) & ({32'd0, b[31:0]} ^ res);
        ovf      = sign_mix[31];
      end
      if (sets_flags) nzcv = {sf ? res[63] : res[31], res == '0, carry, ovf};
      if (rd == adpi_pkg::REG_SP_ZR) begin
        // adds/subs to register 31 only update the flags
        if (!sets_flags) begin
          sp_reg         = res;
          r.dest_written = 1'b1;
        end
      end else begin
        gp_regs[rd]    = res;
        r.dest_written = 1'b1;
      end
    end else if (w[25] && w[23]) begin
      r.handled = 1'b1;
      n_wide++;
      sh = {w[22:21], 4'd0};
      op = {48'd0, w[20:5]} << sh;
      case (opc)
        adpi_pkg::OPC_MOVK: begin
          a   = (rd == adpi_pkg::REG_SP_ZR) ? '0 : gp_regs[rd];
          res = (a & ~(64'hFFFF << sh)) | op;
        end
        adpi_pkg::OPC_MOVZ: res = op;
        default:            res = ~op;
      endcase
      if (!sf) res[63:32] = '0;
      if (rd != adpi_pkg::REG_SP_ZR) begin
        gp_regs[rd]    = res;
        r.dest_written = 1'b1;
      end
    end else begin
      n_other++;
    end
    if (r.dest_written) begin
      r.dest_index = rd;
      r.dest_value = res;
    end
    r.flags_nzcv = nzcv;
    return r;
  endfunction

  function automatic logic [adpi_pkg::INSTR_W-1:0] enc_arith(input logic sf,
      input logic [1:0] opc, input logic sh, input logic [11:0] imm12,
      input logic [4:0] rn, input logic [4:0] rd);
    logic [4:0] spare;
    // bits 28..25 and 23 are don't-care for this group
    spare = 5'($urandom());
    return {sf, opc, spare[4:1], 1'b1, spare[0], sh, imm12, rn, rd};
  endfunction

  function automatic logic [adpi_pkg::INSTR_W-1:0] enc_wide(input logic sf,
      input logic [1:0] opc, input logic [1:0] hw, input logic [15:0] imm16,
      input logic [4:0] rd);
    logic [2:0] spare;
    spare = 3'($urandom());
    return {sf, opc, spare, 3'b101, hw, imm16, rd};
  endfunction

  function automatic logic [4:0] pick_reg(input logic narrow);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return adpi_pkg::REG_SP_ZR;
    if (narrow) return 5'($urandom_range(2));
    if (r < 45) return 5'($urandom_range(3));
    return 5'($urandom_range(30));
  endfunction

  function automatic logic [adpi_pkg::INSTR_W-1:0] random_instr(input logic narrow);
    int unsigned                  kind;
    int unsigned                  pick;
    logic [11:0]                  imm12;
    logic [15:0]                  imm16;
    logic [adpi_pkg::INSTR_W-1:0] w;
    kind  = $urandom_range(99);
    pick  = $urandom_range(9);
    imm12 = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom());
    imm16 = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom());
    if (kind < 45) begin
      w = enc_arith(1'($urandom()), 2'($urandom()), 1'($urandom()), imm12,
                    pick_reg(narrow), pick_reg(narrow));
    end else if (kind < 85) begin
      w = enc_wide(1'($urandom()), 2'($urandom()), 2'($urandom()), imm16,
                   pick_reg(narrow));
    end else if (kind < 93) begin
      // neither group: clear bit 24 and break the wide-move pattern
      w      = $urandom();
      w[24]  = 1'b0;
      w[23]  = w[23] & ~w[25];
    end else begin
      w = $urandom();
    end
    return w;
  endfunction

  task automatic issue(input logic [adpi_pkg::INSTR_W-1:0] w);
    int unsigned gap;
    instr.valid      <= 1'b1;
    instr.instr_word <= w;
    do @(posedge clk); while (!instr.ready);
    expected_q.push_back(execute_instr(w));
    n_issued++;
    gap = pick_gap();
    if (gap != 0) begin
      instr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_drained();
    instr.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_cases();
    issue(enc_wide(1'b1, adpi_pkg::OPC_MOVZ, 2'd3, 16'hFFFF, 5'd0));
    issue(enc_wide(1'b1, adpi_pkg::OPC_MOVK, 2'd0, 16'hFFFF, 5'd0));
    issue(enc_wide(1'b1, adpi_pkg::OPC_MOVN, 2'd0, 16'h0000, 5'd1));
    issue(enc_wide(1'b1, OPC_MOVN_ALT, 2'd1, 16'h1234, 5'd2));
    issue(enc_wide(1'b0, adpi_pkg::OPC_MOVZ, 2'd2, 16'hABCD, 5'd3));
    issue(enc_wide(1'b0, adpi_pkg::OPC_MOVN, 2'd3, 16'hABCD, 5'd4));
    issue(enc_wide(1'b0, adpi_pkg::OPC_MOVK, 2'd2, 16'hABCD, 5'd1));
    issue(enc_wide(1'b1, adpi_pkg::OPC_MOVZ, 2'd0, 16'h5555, adpi_pkg::REG_SP_ZR));
    issue(enc_arith(1'b1, OPC_ADD, 1'b0, 12'hFFF, adpi_pkg::REG_SP_ZR, adpi_pkg::REG_SP_ZR));
    issue(enc_arith(1'b1, OPC_ADD, 1'b1, 12'hFFF, adpi_pkg::REG_SP_ZR, 5'd5));
    issue(enc_arith(1'b1, OPC_ADDS, 1'b0, 12'd1, adpi_pkg::REG_SP_ZR, 5'd6));
    issue(enc_arith(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd1, 5'd7));
    // signed overflow at 64 bits
    issue(enc_wide(1'b1, adpi_pkg::OPC_MOVN, 2'd3, 16'h8000, 5'd8));
    issue(enc_arith(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd8, 5'd9));
    issue(enc_arith(1'b1, OPC_SUBS, 1'b0, 12'd0, adpi_pkg::REG_SP_ZR, adpi_pkg::REG_SP_ZR));
    issue(enc_arith(1'b1, OPC_SUBS, 1'b0, 12'd1, 5'd6, adpi_pkg::REG_SP_ZR));
    issue(enc_arith(1'b0, OPC_SUBS, 1'b1, 12'hFFF, 5'd6, 5'd10));
    issue(enc_arith(1'b0, OPC_ADDS, 1'b0, 12'd1, 5'd4, 5'd11));
    issue(enc_arith(1'b0, OPC_ADD, 1'b0, 12'hFFF, adpi_pkg::REG_SP_ZR, adpi_pkg::REG_SP_ZR));
    issue(enc_arith(1'b1, OPC_SUB, 1'b1, 12'h001, adpi_pkg::REG_SP_ZR, adpi_pkg::REG_SP_ZR));
    // signed overflow at 32 bits
    issue(enc_wide(1'b0, adpi_pkg::OPC_MOVZ, 2'd1, 16'h8000, 5'd12));
    issue(enc_arith(1'b0, OPC_SUBS, 1'b0, 12'd1, 5'd12, 5'd13));
    issue(enc_arith(1'b1, OPC_SUB, 1'b0, 12'd0, adpi_pkg::REG_SP_ZR, 5'd14));
    issue(32'h0000_0000);
    issue(32'hFE7F_FFFF);
    issue(32'hFFFF_FFFF);
  endtask

  // Back-to-back dependent instructions over a few registers exercise forwarding
  task automatic test_forwarding_chain();
    steady_flow = 1'b1;
    repeat (80) issue(random_instr(1'b1));
    steady_flow = 1'b0;
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 500; i++) begin
      steady_flow = ((i >= 150) && (i < 200)) || ((i >= 450) && (i < 500));
      if (i == 300) wait_drained();
      issue(random_instr($urandom_range(3) == 0));
    end
    steady_flow = 1'b0;
  endtask

  initial begin : ready_driver
    int unsigned hold;
    result.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (steady_flow) begin
        result.ready <= 1'b1;
        hold = 0;
      end else if (hold != 0) begin
        result.ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap();
        result.ready <= (hold == 0);
        if (hold != 0) hold--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    exec_result_t want;
    exec_result_t got;
    if (!rst && result.valid && result.ready) begin
      got = {result.handled, result.dest_written, result.dest_index, result.dest_value,
             result.flags_nzcv};
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("ERROR: result with nothing outstanding: handled=%b wr=%b idx=%0d val=%h nzcv=%b",
                   got.handled, got.dest_written, got.dest_index, got.dest_value,
                   got.flags_nzcv);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("ERROR: result %0d expected handled=%b wr=%b idx=%0d val=%h nzcv=%b",
                     n_checked, want.handled, want.dest_written, want.dest_index,
                     want.dest_value, want.flags_nzcv);
            $display("       got                handled=%b wr=%b idx=%0d val=%h nzcv=%b",
                     got.handled, got.dest_written, got.dest_index, got.dest_value,
                     got.flags_nzcv);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((instr.valid && instr.ready) || (result.valid && result.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results outstanding", idle_cycles,
               expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    instr.valid      = 1'b0;
    instr.instr_word = '0;
    steady_flow      = 1'b0;
    n_issued         = 0;
    n_arith          = 0;
    n_wide           = 0;
    n_other          = 0;
    sp_reg           = '0;
    nzcv             = '0;
    foreach (gp_regs[i]) gp_regs[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_forwarding_chain();
    test_random_stream();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Executed %0d instructions (%0d add/sub, %0d wide move, %0d other),",
             n_issued, n_arith, n_wide, n_other);
    $display("%0d results checked under random gaps, stalls and forwarding chains",
             n_checked);
    $display("Mismatches: %0d, results still outstanding: %0d", n_mismatch, expected_q.size());
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
